>>> design/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg: shared types and constants of the integer matrix multiplier
// Holds the request and response beat layouts, the command and register
// codes and the tag that follows one multiply-accumulate through the unit.
// ----------------------------------------------------------------------------
package imm_pkg;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int DATA_W          = 32;
   localparam int IDX_W           = 3;
   localparam int DIM_W           = 4;
   localparam int CSR_INDEX_W     = 2;

   // commands
   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_A = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_B = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_B = 2'd3;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [DATA_W-1:0] product;
      logic                    mismatch;
      logic                    last;
   } rsp_type;

   // control that travels alongside one operand pair
   typedef struct packed {
      logic             valid;
      logic             first;     // first term of a dot product
      logic             last_k;    // last term of a dot product
      logic             last_elem; // last element of the result matrix
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mac_tag_type;

endpackage

>>> design/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read register holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module imm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac: shared multiply-accumulate unit
// Registers the 32-bit wrapped product of one operand pair, then folds it
// into the running dot product; the tag says where a dot product starts/ends.
// ----------------------------------------------------------------------------
module imm_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        zero_terms,
   input  imm_pkg::mac_tag_type        in_tag,
   input  logic [imm_pkg::DATA_W-1:0]  op_a,
   input  logic [imm_pkg::DATA_W-1:0]  op_b,
   output imm_pkg::mac_tag_type        out_tag,
   output logic [imm_pkg::DATA_W-1:0]  out_sum
);

   imm_pkg::mac_tag_type             tag_ff;
   logic [imm_pkg::DATA_W-1:0]       prod_ff;
   logic [imm_pkg::DATA_W-1:0]       prod_in;
   logic [imm_pkg::DATA_W-1:0]       acc_ff;
   logic [imm_pkg::DATA_W-1:0]       sum_in;

   // only the low word survives the wrap
   assign prod_in = zero_terms ? '0 : imm_pkg::DATA_W'(op_a * op_b);
   assign sum_in  = (tag_ff.first ? '0 : acc_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         if (tag_ff.valid) begin
            acc_ff <= sum_in;
         end
      end
   end

   assign out_tag = tag_ff;
   assign out_sum = sum_in;

endmodule

>>> design/integer_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core: signed integer matrix multiplier
// Stores matrices A and B element by element and streams C = A x B.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat either writes one element of A or B or starts a
//   compute. csr channel: writes rows_a, cols_a, rows_b,
//   cols_b; always ready, write only while the block is idle.
//   rsp channel: a compute returns rows_a*cols_b beats in row-major order,
//   the final one flagged with last. If cols_a differs from rows_b every beat
//   carries a zero product with mismatch set.
//   Throughput: one shared multiply-accumulate unit fed by the two element
//   RAMs takes one term per cycle while the rsp channel is not stalled, and
//   a result element takes cols_a terms (a single one on a mismatch). Terms
//   pass through the RAM read register and the product register, and each
//   sum is loaded into the output register. req_ready stays low from the
//   compute beat until the last rsp beat has been taken.
//   Stall: while rsp_valid is high and rsp_ready low, the whole read and
//   multiply pipeline freezes and no data is lost.
//   Reset: dimension registers return to 1 and the pipeline empties; the
//   element stores are not cleared, so an element must be written before a
//   compute reads it.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  imm_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output imm_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [imm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [imm_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int AW      = $clog2(DEPTH);
   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
   localparam int CW      = $clog2(DIM_CAP);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [imm_pkg::DIM_W-1:0]  rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [CW-1:0]              i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0]              i_last, j_last, m_last, x_last, k_last;
   logic                       bad;
   logic                       advance;
   logic                       req_fire;
   logic                       wr_ok;
   logic [AW-1:0]              wr_addr, a_rd_addr, b_rd_addr;
   logic [imm_pkg::DATA_W-1:0] a_rd_data, b_rd_data;
   imm_pkg::mac_tag_type       issue_tag, s1_tag_ff, mac_tag;
   logic [imm_pkg::DATA_W-1:0] mac_sum;
   logic                       rsp_valid_ff, rsp_valid_in;
   imm_pkg::rsp_type           rsp_ff;
   logic                       load_rsp;

   // saturate a dimension register to 1..DIM_CAP and give its last index
   function automatic logic [CW-1:0] dim_last(input logic [imm_pkg::DIM_W-1:0] r);
      logic [CW-1:0] res;
      if (r == '0) begin
         res = '0;
      end else if (32'(r) > DIM_CAP) begin
         res = CW'(DIM_CAP - 1);
      end else begin
         res = CW'(r - imm_pkg::DIM_W'(1));
      end
      return res;
   endfunction

   assign i_last = dim_last(rows_a_ff);
   assign m_last = dim_last(cols_a_ff);
   assign x_last = dim_last(rows_b_ff);
   assign j_last = dim_last(cols_b_ff);
   assign bad    = (m_last != x_last);
   assign k_last = bad ? '0 : m_last;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= imm_pkg::DIM_W'(1);
         cols_a_ff <= imm_pkg::DIM_W'(1);
         rows_b_ff <= imm_pkg::DIM_W'(1);
         cols_b_ff <= imm_pkg::DIM_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            imm_pkg::CSR_ROWS_A: rows_a_ff <= csr_wdata;
            imm_pkg::CSR_COLS_A: cols_a_ff <= csr_wdata;
            imm_pkg::CSR_ROWS_B: rows_b_ff <= csr_wdata;
            imm_pkg::CSR_COLS_B: cols_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // element writes
   assign wr_ok   = (32'(req_payload.row) < MAX_DIM) && (32'(req_payload.col) < MAX_DIM);
   assign wr_addr = AW'(req_payload.row) * AW'(MAX_DIM) + AW'(req_payload.col);

   assign a_rd_addr = AW'(i_ff) * AW'(MAX_DIM) + AW'(k_ff);
   assign b_rd_addr = AW'(k_ff) * AW'(MAX_DIM) + AW'(j_ff);

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (req_fire && wr_ok && (req_payload.cmd == imm_pkg::CMD_WRITE_A)),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (advance),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (req_fire && wr_ok && (req_payload.cmd == imm_pkg::CMD_WRITE_B)),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (advance),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // term issue: walks i, j, k with k innermost
   always_comb begin
      issue_tag           = '0;
      issue_tag.valid     = (state_ff == ST_RUN);
      issue_tag.first     = (k_ff == '0);
      issue_tag.last_k    = (k_ff == k_last);
      issue_tag.last_elem = (k_ff == k_last) && (j_ff == j_last) && (i_ff == i_last);
      issue_tag.row       = imm_pkg::IDX_W'(i_ff);
      issue_tag.col       = imm_pkg::IDX_W'(j_ff);
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_payload.cmd == imm_pkg::CMD_COMPUTE)) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (k_ff == k_last) begin
                  k_in = '0;
                  if (j_ff == j_last) begin
                     j_in = '0;
                     if (i_ff == i_last) begin
                        state_in = ST_DRAIN;
                     end else begin
                        i_in = i_ff + CW'(1);
                     end
                  end else begin
                     j_in = j_ff + CW'(1);
                  end
               end else begin
                  k_in = k_ff + CW'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_valid_ff && rsp_ready && rsp_ff.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // tag lines up with the registered ram read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else if (advance) begin
         s1_tag_ff <= issue_tag;
      end
   end

   imm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .zero_terms (bad),
      .in_tag     (s1_tag_ff),
      .op_a       (a_rd_data),
      .op_b       (b_rd_data),
      .out_tag    (mac_tag),
      .out_sum    (mac_sum)
   );

   // output register
   assign load_rsp = advance && mac_tag.valid && mac_tag.last_k;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.out_row  <= mac_tag.row;
         rsp_ff.out_col  <= mac_tag.col;
         rsp_ff.product  <= mac_sum;
         rsp_ff.mismatch <= bad;
         rsp_ff.last     <= mac_tag.last_elem;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
